// ----- hdl/scsbp_pkg.sv -----
// Shared types, codes and sizing constants for the size-class block pool manager.
package scsbp_pkg;

    // Class table geometry: class i holds (1 << (LOG2_MIN_CLASS + i)) bytes
    localparam int NUM_CLASSES      = 19;
    localparam int CLASS_W          = 5;
    localparam int LOG2_MIN_CLASS   = 7;
    localparam int HEADER_BYTES     = 32;
    localparam int DESCRIPTOR_BYTES = 96;
    localparam int ABS_MAX_MESSAGE  = 33554432;
    localparam int INFLIGHT_LIMIT   = 65536;

    // Offset from wire size to (class need - 1), so a fit test is a strict compare
    localparam int NEED_OFS = DESCRIPTOR_BYTES - HEADER_BYTES - 1;

    // Field and datapath widths
    localparam int MSG_W    = 26;
    localparam int CNT_W    = 17;
    localparam int BYTES_W  = 42;
    localparam int ALU_W    = 43;
    localparam int SHAMT_W  = 6;
    localparam int SEQ_W    = 64;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 232;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 26;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MESSAGE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_INFLIGHT = 1'b1;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RETIRE  = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_META  = 3'd1,
        ST_BAD_INSP  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_FAULT     = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TOP,
        S_REQ,
        S_LIMIT,
        S_CACHE,
        S_EVICT_CNT,
        S_ROOM,
        S_BUDGET,
        S_EVICT_BYTES,
        S_FRESH,
        S_REL,
        S_RET_SHIFT,
        S_RET_SUB,
        S_DONE
    } t_state;

    // Shared adder/shifter: y = a +/- (use_shift ? s << (LOG2_MIN_CLASS + sh) : b)
    typedef struct packed {
        logic               sub;
        logic               use_shift;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
        logic [CNT_W-1:0]   s;
        logic [CLASS_W-1:0] sh;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             borrow;
    } t_alu_rsp;

    // Write port of the per-class free count store
    typedef struct packed {
        logic               en;
        logic [CLASS_W-1:0] idx;
        logic [CNT_W-1:0]   data;
    } t_store_wr;

endpackage

// ----- hdl/scsbp_alu.sv -----
// Shared shift and add/subtract unit used by the arithmetic steps of the sequencer.
module scsbp_alu (
    input  scsbp_pkg::t_alu_req i_req,
    output scsbp_pkg::t_alu_rsp o_rsp
);

    logic [scsbp_pkg::SHAMT_W-1:0] w_shamt;
    logic [scsbp_pkg::ALU_W-1:0]   w_shifted;
    logic [scsbp_pkg::ALU_W-1:0]   w_b;
    logic [scsbp_pkg::ALU_W:0]     w_sum;

    // Scale the operand by the class size
    assign w_shamt   = scsbp_pkg::SHAMT_W'(i_req.sh) +
                       scsbp_pkg::SHAMT_W'(scsbp_pkg::LOG2_MIN_CLASS);
    assign w_shifted = scsbp_pkg::ALU_W'(i_req.s) << w_shamt;
    assign w_b       = i_req.use_shift ? w_shifted : i_req.b;

    // Add or subtract; the top bit is the carry or borrow
    assign w_sum = i_req.sub ? ({1'b0, i_req.a} - {1'b0, w_b})
                             : ({1'b0, i_req.a} + {1'b0, w_b});

    assign o_rsp.y      = w_sum[scsbp_pkg::ALU_W-1:0];
    assign o_rsp.borrow = w_sum[scsbp_pkg::ALU_W];

endmodule

// ----- hdl/scsbp_class_store.sv -----
// Per-class free block counts, one write and one read per cycle.
module scsbp_class_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scsbp_pkg::t_store_wr          i_wr,
    input  logic [scsbp_pkg::CLASS_W-1:0] i_rd_idx,
    output logic [scsbp_pkg::CNT_W-1:0]   o_rd_data
);

    logic [scsbp_pkg::CNT_W-1:0] r_free [scsbp_pkg::NUM_CLASSES];

    // Clear all lists on reset, update one entry per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < scsbp_pkg::NUM_CLASSES; k++) begin
                r_free[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_free[i_wr.idx] <= i_wr.data;
        end
    end

    // Read as empty beyond the table
    assign o_rd_data = (i_rd_idx < scsbp_pkg::CLASS_W'(scsbp_pkg::NUM_CLASSES)) ?
                       r_free[i_rd_idx] : '0;

endmodule

// ----- hdl/size_class_block_pool_manager_core.sv -----
// From accept to result: a rejected acquire ends at the check; a retire sweeps every class;
// a release scans for the largest usable class, then updates its list; an acquire scans for
// the largest usable and requested classes, checks limit and cache, and on a miss evicts as
// needed and allocates a fresh block. One request at a time, taken only in idle: arithmetic
// steps share one adder/shifter, and the output register frees the sequencer early.
// Synchronous active-low reset clears counters, class lists and retire flag; config resets.
module size_class_block_pool_manager_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [25:0] message_bytes, [26] inspection_ok, [27] run_id_zero, [91:28] global_sequence,
    // [155:92] source_sequence, [219:156] tick_sequence, [224:220] release_class, zero pad
    input  logic [scsbp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] op, [3:2] source_kind
    input  logic [scsbp_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [4:0] granted_class, [21:5] active_count, [38:22] allocated_count,
    // [55:39] cached_count, [97:56] allocated_total_bytes, [98] is_retired, zero pad
    output logic [scsbp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status
    output logic [scsbp_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [scsbp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [scsbp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int OUT_USED_W = scsbp_pkg::CLASS_W + 3 * scsbp_pkg::CNT_W +
                                scsbp_pkg::BYTES_W + 1;
    localparam int OUT_PAD_W  = scsbp_pkg::OUT_TDATA_W - OUT_USED_W;
    localparam logic [scsbp_pkg::CLASS_W-1:0] LAST_CLASS =
        scsbp_pkg::CLASS_W'(scsbp_pkg::NUM_CLASSES - 1);

    // Control and state registers
    scsbp_pkg::t_state               r_state, n_state;
    logic                            r_out_valid, n_out_valid;
    logic [scsbp_pkg::CNT_W-1:0]     r_active, n_active;
    logic [scsbp_pkg::CNT_W-1:0]     r_owned, n_owned;
    logic [scsbp_pkg::CNT_W-1:0]     r_cached, n_cached;
    logic [scsbp_pkg::BYTES_W-1:0]   r_bytes, n_bytes;
    logic                            r_retired, n_retired;
    logic [scsbp_pkg::MSG_W-1:0]     r_cfg_max_msg;
    logic [scsbp_pkg::CNT_W-1:0]     r_cfg_inflight;

    // Request payload and working registers
    logic [scsbp_pkg::OP_W-1:0]      r_op, n_op;
    logic [scsbp_pkg::MSG_W-1:0]     r_msg, n_msg;
    logic                            r_insp, n_insp;
    logic                            r_runz, n_runz;
    logic [scsbp_pkg::SEQ_W-1:0]     r_gseq, n_gseq;
    logic [scsbp_pkg::SEQ_W-1:0]     r_sseq, n_sseq;
    logic [scsbp_pkg::SEQ_W-1:0]     r_tseq, n_tseq;
    logic [scsbp_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic [scsbp_pkg::CLASS_W-1:0]   r_cls, n_cls;
    logic [scsbp_pkg::CLASS_W-1:0]   r_idx, n_idx;
    logic [scsbp_pkg::CLASS_W-1:0]   r_top, n_top;
    logic [scsbp_pkg::CLASS_W-1:0]   r_req, n_req;
    logic [scsbp_pkg::ALU_W-1:0]     r_need_top, n_need_top;
    logic [scsbp_pkg::ALU_W-1:0]     r_need_req, n_need_req;
    logic [scsbp_pkg::ALU_W-1:0]     r_budget, n_budget;
    logic [scsbp_pkg::ALU_W-1:0]     r_room, n_room;
    logic                            r_room_neg, n_room_neg;
    logic [scsbp_pkg::ALU_W-1:0]     r_opnd, n_opnd;
    scsbp_pkg::t_status              r_status, n_status;
    logic [scsbp_pkg::CLASS_W-1:0]   r_granted, n_granted;

    // Output register payload
    scsbp_pkg::t_status              r_out_status;
    logic [scsbp_pkg::CLASS_W-1:0]   r_out_granted;
    logic [scsbp_pkg::CNT_W-1:0]     r_out_active;
    logic [scsbp_pkg::CNT_W-1:0]     r_out_owned;
    logic [scsbp_pkg::CNT_W-1:0]     r_out_cached;
    logic [scsbp_pkg::BYTES_W-1:0]   r_out_bytes;
    logic                            r_out_retired;

    // Shared unit and class store hookup
    scsbp_pkg::t_alu_req             w_alu_req;
    scsbp_pkg::t_alu_rsp             w_alu_rsp;
    scsbp_pkg::t_store_wr            w_store_wr;
    logic [scsbp_pkg::CLASS_W-1:0]   w_rd_idx;
    logic [scsbp_pkg::CNT_W-1:0]     w_rd_data;

    // Decisions
    logic                            w_in_accept;
    logic                            w_slot_free;
    logic [scsbp_pkg::MSG_W-1:0]     w_eff_max;
    logic [scsbp_pkg::CNT_W-1:0]     w_limit;
    logic                            w_meta_bad;
    logic                            w_insp_bad;
    logic                            w_tick_bad;
    logic                            w_large;
    logic                            w_acq_fail;
    logic                            w_fits;
    logic                            w_last;
    logic                            w_free_nz;
    logic                            w_owned_full;
    logic                            w_limit_fail;
    logic                            w_over;
    logic                            w_rel_fault;

    scsbp_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    scsbp_class_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_store_wr),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    // Saturate the configuration into its usable range
    always_comb begin
        if (r_cfg_max_msg < scsbp_pkg::MSG_W'(scsbp_pkg::HEADER_BYTES)) begin
            w_eff_max = scsbp_pkg::MSG_W'(scsbp_pkg::HEADER_BYTES);
        end else if (r_cfg_max_msg > scsbp_pkg::MSG_W'(scsbp_pkg::ABS_MAX_MESSAGE)) begin
            w_eff_max = scsbp_pkg::MSG_W'(scsbp_pkg::ABS_MAX_MESSAGE);
        end else begin
            w_eff_max = r_cfg_max_msg;
        end
        if (r_cfg_inflight == '0) begin
            w_limit = scsbp_pkg::CNT_W'(1);
        end else if (r_cfg_inflight > scsbp_pkg::CNT_W'(scsbp_pkg::INFLIGHT_LIMIT)) begin
            w_limit = scsbp_pkg::CNT_W'(scsbp_pkg::INFLIGHT_LIMIT);
        end else begin
            w_limit = r_cfg_inflight;
        end
    end

    // Acquire validation
    assign w_meta_bad = r_runz || (r_gseq == '0) || (r_sseq == '0) || (r_gseq == '1) ||
                        (r_sseq == '1) || (r_tseq == '1) || (r_tseq > r_gseq);
    assign w_insp_bad = !r_insp || (r_msg < scsbp_pkg::MSG_W'(scsbp_pkg::HEADER_BYTES)) ||
                        (r_msg > scsbp_pkg::MSG_W'(scsbp_pkg::ABS_MAX_MESSAGE));
    assign w_tick_bad = r_kind[0] ? (r_tseq == '0) : (r_tseq != '0);
    assign w_large    = r_msg > w_eff_max;
    assign w_acq_fail = w_meta_bad || w_insp_bad || w_tick_bad || w_large;

    // Step conditions
    assign w_fits       = w_alu_rsp.borrow;
    assign w_last       = r_idx == LAST_CLASS;
    assign w_free_nz    = w_rd_data != '0;
    assign w_owned_full = r_owned >= w_limit;
    assign w_limit_fail = r_retired || (r_active >= w_limit);
    assign w_over       = r_room_neg || w_alu_rsp.borrow;
    assign w_rel_fault  = (r_active == '0) || (r_cls > r_top);

    assign w_rd_idx = (r_state == scsbp_pkg::S_REL) ? r_cls : r_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scsbp_pkg::S_IDLE: begin
                if (w_in_accept) n_state = scsbp_pkg::S_CHECK;
            end
            scsbp_pkg::S_CHECK: begin
                unique case (r_op)
                    scsbp_pkg::OP_ACQUIRE: begin
                        n_state = w_acq_fail ? scsbp_pkg::S_DONE : scsbp_pkg::S_TOP;
                    end
                    scsbp_pkg::OP_RELEASE: n_state = scsbp_pkg::S_TOP;
                    scsbp_pkg::OP_RETIRE: begin
                        n_state = r_retired ? scsbp_pkg::S_DONE : scsbp_pkg::S_RET_SHIFT;
                    end
                    default: n_state = scsbp_pkg::S_DONE;
                endcase
            end
            scsbp_pkg::S_TOP: begin
                if (w_fits || w_last) begin
                    n_state = (r_op == scsbp_pkg::OP_ACQUIRE) ? scsbp_pkg::S_REQ
                                                              : scsbp_pkg::S_REL;
                end
            end
            scsbp_pkg::S_REQ: begin
                if (w_fits) begin
                    n_state = scsbp_pkg::S_LIMIT;
                end else if (r_idx == r_top) begin
                    n_state = scsbp_pkg::S_DONE;
                end
            end
            scsbp_pkg::S_LIMIT: begin
                n_state = w_limit_fail ? scsbp_pkg::S_DONE : scsbp_pkg::S_CACHE;
            end
            scsbp_pkg::S_CACHE: begin
                if (w_free_nz) begin
                    n_state = scsbp_pkg::S_DONE;
                end else if (r_idx == r_top) begin
                    n_state = scsbp_pkg::S_EVICT_CNT;
                end
            end
            scsbp_pkg::S_EVICT_CNT: begin
                if (!w_owned_full) begin
                    n_state = scsbp_pkg::S_ROOM;
                end else if (!w_free_nz && (r_idx == '0)) begin
                    n_state = scsbp_pkg::S_DONE;
                end
            end
            scsbp_pkg::S_ROOM: n_state = scsbp_pkg::S_BUDGET;
            scsbp_pkg::S_BUDGET: begin
                n_state = w_over ? scsbp_pkg::S_EVICT_BYTES : scsbp_pkg::S_FRESH;
            end
            scsbp_pkg::S_EVICT_BYTES: begin
                if (w_free_nz) begin
                    n_state = scsbp_pkg::S_BUDGET;
                end else if (r_idx == '0) begin
                    n_state = scsbp_pkg::S_DONE;
                end
            end
            scsbp_pkg::S_FRESH:     n_state = scsbp_pkg::S_DONE;
            scsbp_pkg::S_REL:       n_state = scsbp_pkg::S_DONE;
            scsbp_pkg::S_RET_SHIFT: n_state = scsbp_pkg::S_RET_SUB;
            scsbp_pkg::S_RET_SUB: begin
                n_state = w_last ? scsbp_pkg::S_DONE : scsbp_pkg::S_RET_SHIFT;
            end
            scsbp_pkg::S_DONE: begin
                if (w_slot_free) n_state = scsbp_pkg::S_IDLE;
            end
            default: n_state = scsbp_pkg::S_IDLE;
        endcase
    end

    // Datapath control and next register values
    always_comb begin
        n_active   = r_active;
        n_owned    = r_owned;
        n_cached   = r_cached;
        n_bytes    = r_bytes;
        n_retired  = r_retired;
        n_op       = r_op;
        n_msg      = r_msg;
        n_insp     = r_insp;
        n_runz     = r_runz;
        n_gseq     = r_gseq;
        n_sseq     = r_sseq;
        n_tseq     = r_tseq;
        n_kind     = r_kind;
        n_cls      = r_cls;
        n_idx      = r_idx;
        n_top      = r_top;
        n_req      = r_req;
        n_need_top = r_need_top;
        n_need_req = r_need_req;
        n_budget   = r_budget;
        n_room     = r_room;
        n_room_neg = r_room_neg;
        n_opnd     = r_opnd;
        n_status   = r_status;
        n_granted  = r_granted;

        w_alu_req.sub       = 1'b1;
        w_alu_req.use_shift = 1'b1;
        w_alu_req.a         = '0;
        w_alu_req.b         = '0;
        w_alu_req.s         = scsbp_pkg::CNT_W'(1);
        w_alu_req.sh        = r_idx;

        w_store_wr.en   = 1'b0;
        w_store_wr.idx  = r_idx;
        w_store_wr.data = w_rd_data - scsbp_pkg::CNT_W'(1);

        unique case (r_state)
            // Capture the request
            scsbp_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_op      = i_s_axis_tuser[1:0];
                    n_kind    = i_s_axis_tuser[3:2];
                    n_msg     = i_s_axis_tdata[25:0];
                    n_insp    = i_s_axis_tdata[26];
                    n_runz    = i_s_axis_tdata[27];
                    n_gseq    = i_s_axis_tdata[91:28];
                    n_sseq    = i_s_axis_tdata[155:92];
                    n_tseq    = i_s_axis_tdata[219:156];
                    n_cls     = i_s_axis_tdata[224:220];
                    n_status  = scsbp_pkg::ST_OK;
                    n_granted = '0;
                end
            end
            // Validate and prepare the class searches
            scsbp_pkg::S_CHECK: begin
                n_idx      = '0;
                n_need_top = scsbp_pkg::ALU_W'(w_eff_max) +
                             scsbp_pkg::ALU_W'(scsbp_pkg::NEED_OFS);
                n_need_req = scsbp_pkg::ALU_W'(r_msg) +
                             scsbp_pkg::ALU_W'(scsbp_pkg::NEED_OFS);
                unique case (r_op)
                    scsbp_pkg::OP_ACQUIRE: begin
                        priority if (w_meta_bad) n_status = scsbp_pkg::ST_BAD_META;
                        else if (w_insp_bad)     n_status = scsbp_pkg::ST_BAD_INSP;
                        else if (w_tick_bad)     n_status = scsbp_pkg::ST_BAD_META;
                        else if (w_large)        n_status = scsbp_pkg::ST_TOO_LARGE;
                        else                     n_status = scsbp_pkg::ST_OK;
                    end
                    scsbp_pkg::OP_RELEASE: n_status = scsbp_pkg::ST_OK;
                    scsbp_pkg::OP_RETIRE:  n_retired = 1'b1;
                    default:               n_status = scsbp_pkg::ST_FAULT;
                endcase
            end
            // Largest usable class: first class whose size reaches the need, else the last class
            scsbp_pkg::S_TOP: begin
                w_alu_req.a = r_need_top;
                if (w_fits || w_last) begin
                    n_top = r_idx;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + scsbp_pkg::CLASS_W'(1);
                end
            end
            // Requested class, no higher than the largest usable class
            scsbp_pkg::S_REQ: begin
                w_alu_req.a = r_need_req;
                if (w_fits) begin
                    n_req = r_idx;
                    n_idx = r_idx;
                end else if (r_idx == r_top) begin
                    n_status = scsbp_pkg::ST_TOO_LARGE;
                end else begin
                    n_idx = r_idx + scsbp_pkg::CLASS_W'(1);
                end
            end
            // Active limit, and the byte budget for the largest usable class
            scsbp_pkg::S_LIMIT: begin
                w_alu_req.sub = 1'b0;
                w_alu_req.s   = w_limit;
                w_alu_req.sh  = r_top;
                n_budget      = w_alu_rsp.y;
                if (w_limit_fail) n_status = scsbp_pkg::ST_EXHAUSTED;
            end
            // Take a cached block from the requested class or a larger one
            scsbp_pkg::S_CACHE: begin
                if (w_free_nz) begin
                    w_store_wr.en = 1'b1;
                    n_cached      = r_cached - scsbp_pkg::CNT_W'(1);
                    n_active      = r_active + scsbp_pkg::CNT_W'(1);
                    n_granted     = r_idx;
                end else if (r_idx == r_top) begin
                    n_idx = LAST_CLASS;
                end else begin
                    n_idx = r_idx + scsbp_pkg::CLASS_W'(1);
                end
            end
            // Evict from the largest class down until the block count fits
            scsbp_pkg::S_EVICT_CNT: begin
                w_alu_req.a = scsbp_pkg::ALU_W'(r_bytes);
                if (w_owned_full) begin
                    if (w_free_nz) begin
                        w_store_wr.en = 1'b1;
                        n_cached = (r_cached != '0) ? r_cached - scsbp_pkg::CNT_W'(1) : '0;
                        n_owned  = (r_owned != '0) ? r_owned - scsbp_pkg::CNT_W'(1) : '0;
                        n_bytes  = w_alu_rsp.borrow ? '0 : w_alu_rsp.y[scsbp_pkg::BYTES_W-1:0];
                    end else if (r_idx == '0) begin
                        n_status = scsbp_pkg::ST_EXHAUSTED;
                    end else begin
                        n_idx = r_idx - scsbp_pkg::CLASS_W'(1);
                    end
                end
            end
            // Room left in the budget once the new block is counted
            scsbp_pkg::S_ROOM: begin
                w_alu_req.a  = r_budget;
                w_alu_req.sh = r_req;
                n_room       = w_alu_rsp.y;
                n_room_neg   = w_alu_rsp.borrow;
            end
            // Compare owned bytes against the room
            scsbp_pkg::S_BUDGET: begin
                w_alu_req.use_shift = 1'b0;
                w_alu_req.a         = r_room;
                w_alu_req.b         = scsbp_pkg::ALU_W'(r_bytes);
            end
            // Evict one block for the byte budget, or move to the next class down
            scsbp_pkg::S_EVICT_BYTES: begin
                w_alu_req.a = scsbp_pkg::ALU_W'(r_bytes);
                if (w_free_nz) begin
                    w_store_wr.en = 1'b1;
                    n_cached = (r_cached != '0) ? r_cached - scsbp_pkg::CNT_W'(1) : '0;
                    n_owned  = (r_owned != '0) ? r_owned - scsbp_pkg::CNT_W'(1) : '0;
                    n_bytes  = w_alu_rsp.borrow ? '0 : w_alu_rsp.y[scsbp_pkg::BYTES_W-1:0];
                end else if (r_idx == '0) begin
                    n_status = scsbp_pkg::ST_EXHAUSTED;
                end else begin
                    n_idx = r_idx - scsbp_pkg::CLASS_W'(1);
                end
            end
            // Allocate a fresh block of the requested class
            scsbp_pkg::S_FRESH: begin
                w_alu_req.sub = 1'b0;
                w_alu_req.a   = scsbp_pkg::ALU_W'(r_bytes);
                w_alu_req.sh  = r_req;
                n_bytes       = w_alu_rsp.y[scsbp_pkg::BYTES_W-1:0];
                n_owned       = r_owned + scsbp_pkg::CNT_W'(1);
                n_active      = r_active + scsbp_pkg::CNT_W'(1);
                n_granted     = r_req;
            end
            // Return a block to its list, or free it after retire
            scsbp_pkg::S_REL: begin
                w_alu_req.a     = scsbp_pkg::ALU_W'(r_bytes);
                w_alu_req.sh    = r_cls;
                w_store_wr.idx  = r_cls;
                w_store_wr.data = w_rd_data + scsbp_pkg::CNT_W'(1);
                if (w_rel_fault) begin
                    n_status = scsbp_pkg::ST_FAULT;
                end else if (r_retired) begin
                    if ((r_owned == '0) || w_alu_rsp.borrow) begin
                        n_status = scsbp_pkg::ST_FAULT;
                    end else begin
                        n_active = r_active - scsbp_pkg::CNT_W'(1);
                        n_owned  = r_owned - scsbp_pkg::CNT_W'(1);
                        n_bytes  = w_alu_rsp.y[scsbp_pkg::BYTES_W-1:0];
                    end
                end else begin
                    w_store_wr.en = 1'b1;
                    n_active      = r_active - scsbp_pkg::CNT_W'(1);
                    n_cached      = r_cached + scsbp_pkg::CNT_W'(1);
                end
            end
            // Retire sweep: bytes held by this class's list
            scsbp_pkg::S_RET_SHIFT: begin
                w_alu_req.sub = 1'b0;
                w_alu_req.s   = w_rd_data;
                n_opnd        = w_alu_rsp.y;
            end
            // Retire sweep: drop the list with saturating counters
            scsbp_pkg::S_RET_SUB: begin
                w_alu_req.use_shift = 1'b0;
                w_alu_req.a         = scsbp_pkg::ALU_W'(r_bytes);
                w_alu_req.b         = r_opnd;
                w_store_wr.en       = 1'b1;
                w_store_wr.data     = '0;
                n_bytes  = w_alu_rsp.borrow ? '0 : w_alu_rsp.y[scsbp_pkg::BYTES_W-1:0];
                n_cached = (r_cached >= w_rd_data) ? r_cached - w_rd_data : '0;
                n_owned  = (r_owned >= w_rd_data) ? r_owned - w_rd_data : '0;
                if (!w_last) n_idx = r_idx + scsbp_pkg::CLASS_W'(1);
            end
            scsbp_pkg::S_DONE: begin
                n_idx = r_idx;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // Output register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == scsbp_pkg::S_DONE) && w_slot_free) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scsbp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_owned     <= '0;
            r_cached    <= '0;
            r_bytes     <= '0;
            r_retired   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
            r_owned     <= n_owned;
            r_cached    <= n_cached;
            r_bytes     <= n_bytes;
            r_retired   <= n_retired;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_max_msg  <= scsbp_pkg::MSG_W'(65536);
            r_cfg_inflight <= scsbp_pkg::CNT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                scsbp_pkg::CFG_MAX_MESSAGE:  r_cfg_max_msg  <= i_cfg_wdata;
                scsbp_pkg::CFG_MAX_INFLIGHT: r_cfg_inflight <= i_cfg_wdata[16:0];
                default:                     r_cfg_inflight <= r_cfg_inflight;
            endcase
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_msg      <= n_msg;
        r_insp     <= n_insp;
        r_runz     <= n_runz;
        r_gseq     <= n_gseq;
        r_sseq     <= n_sseq;
        r_tseq     <= n_tseq;
        r_kind     <= n_kind;
        r_cls      <= n_cls;
        r_idx      <= n_idx;
        r_top      <= n_top;
        r_req      <= n_req;
        r_need_top <= n_need_top;
        r_need_req <= n_need_req;
        r_budget   <= n_budget;
        r_room     <= n_room;
        r_room_neg <= n_room_neg;
        r_opnd     <= n_opnd;
        r_status   <= n_status;
        r_granted  <= n_granted;
    end

    // Load the result into the output register
    always_ff @(posedge i_clk) begin
        if ((r_state == scsbp_pkg::S_DONE) && w_slot_free) begin
            r_out_status  <= r_status;
            r_out_granted <= (r_status == scsbp_pkg::ST_OK) ? r_granted : '0;
            r_out_active  <= r_active;
            r_out_owned   <= r_owned;
            r_out_cached  <= r_cached;
            r_out_bytes   <= r_bytes;
            r_out_retired <= r_retired;
        end
    end

    assign o_s_axis_tready = r_state == scsbp_pkg::S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_retired, r_out_bytes, r_out_cached,
                              r_out_owned, r_out_active, r_out_granted};

endmodule
